// ===== hw/rtl/first_fit_block_allocator_unit_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define FFBA_ASSERT_NOW(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define FFBA_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ffba_pkg.sv =====
// Package: constants, codes and types of the first-fit block allocator.
package ffba_pkg;

	localparam int ADDR_W        = 10;
	localparam int LEN_W         = 16;
	localparam int CMD_W         = 2;
	localparam int GRANULE_BYTES = 16;
	localparam int GRAN_SH       = $clog2(GRANULE_BYTES);
	localparam int POOL_BYTES_DEF = 1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_RESET = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_INIT,
		S_A_RD,
		S_A_CHK,
		S_A_SPN,
		S_A_SPS,
		S_A_MARK,
		S_F_RDH,
		S_F_CHKH,
		S_F_RDN,
		S_F_CHKN,
		S_F_WRH,
		S_F_RDW,
		S_F_CHKW,
		S_F_MRG
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} alu_flags_t;

endpackage

// ===== hw/rtl/first_fit_block_allocator_unit.sv =====
// Top level: first-fit block allocator with header RAM and walk sequencer.
//
//  channel   | handshake         | payload
//  ----------+-------------------+----------------------------------------------------
//  command   | start / busy      | command, request_length, payload_address,
//            |                   | address_is_null
//  result    | done (one cycle)  | result_address, success
//
// A beat is taken when start is high and busy is low. Reset pool, an unknown
// command, a null or out-of-pool free and an allocate of zero on a ready pool
// answer in the next cycle. An allocate walks headers, reading and then checking
// each, then splits the first fitting block where room allows and marks it used.
// A free checks its header and the next one, writes the header back, then walks
// the headers ahead of it to fold it into a free predecessor. The single RAM port
// pair and the shared adder serialise these steps. arst_n clears the sequencer,
// the ready flag and the strobe; header contents stay undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per beat.
module first_fit_block_allocator_unit #(
	parameter int POOL_BYTES = ffba_pkg::POOL_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ffba_pkg::CMD_W-1:0]  command,
	input  logic [ffba_pkg::LEN_W-1:0]  request_length,
	input  logic [ffba_pkg::ADDR_W-1:0] payload_address,
	input  logic                        address_is_null,
	output logic                        done,
	output logic [ffba_pkg::ADDR_W-1:0] result_address,
	output logic                        success
);
	import ffba_pkg::*;

	`include "first_fit_block_allocator_unit_macros.svh"

	localparam int G      = POOL_BYTES / GRANULE_BYTES;
	localparam int GW     = $clog2(G);
	localparam int HDR_W  = GW + 1;
	localparam int NEED_W = LEN_W + 1 - GRAN_SH;
	localparam int CW     = ((NEED_W > GW + 1) ? NEED_W : GW + 1) + 1;

	localparam logic [CW-1:0] G_CW    = CW'(G);
	localparam logic [GW-1:0] GMAX_GW = GW'(G - 1);

	// sequencer and control
	state_t state_q, state_d;
	logic   ready_q;
	logic   done_q;
	logic   acc;

	// datapath registers
	logic [CW-1:0]     cur_q;
	logic [CW-1:0]     need_q;
	logic [CW-1:0]     need_p2_q;
	logic [GW-1:0]     h_q;
	logic [GW-1:0]     nxt_q;
	logic [GW-1:0]     nb_q;
	logic [GW-1:0]     sz_q;
	logic [GW-1:0]     szh_q;
	logic [GW-1:0]     mark_q;
	logic [ADDR_W-1:0] addr_q;
	logic              ok_q;

	// decoded accept-time values
	logic [LEN_W:0]    need_sum;
	logic [LEN_W:0]    need_full;
	logic [CW-1:0]     need_d;
	logic [ADDR_W-1:0] pg;
	logic [CW-1:0]     pg_x;
	logic              pg_ok;

	// RAM
	logic             ram_we;
	logic [GW-1:0]    ram_waddr;
	logic [HDR_W-1:0] ram_wdata;
	logic [GW-1:0]    ram_raddr;
	logic [HDR_W-1:0] ram_rdata;
	logic [GW-1:0]    rd_sz;
	logic             rd_used;
	logic [CW-1:0]    rd_sz_x;
	logic             fit;
	logic             big;

	// shared unit
	logic       alu_cin;
	logic       alu_sub;
	logic [CW-1:0] alu_a;
	logic [CW-1:0] alu_b;
	logic [CW-1:0] alu_c;
	logic [CW-1:0] alu_sum;
	alu_flags_t alu_flags;
	logic [GW-1:0] alu_sat;
	logic [CW+GRAN_SH-1:0] byte_off;

	// finish strobe for the sequencer
	logic              fin;
	logic              fin_ok;
	logic [ADDR_W-1:0] fin_addr;

	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(G)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ffba_alu #(
		.W(CW)
	) u_alu (
		.cin  (alu_cin),
		.sub  (alu_sub),
		.a    (alu_a),
		.b    (alu_b),
		.c    (alu_c),
		.sum  (alu_sum),
		.flags(alu_flags)
	);

	assign busy = state_q != S_IDLE;
	assign acc  = start && !busy;

	// round the length up to whole granules
	assign need_sum  = {1'b0, request_length} + (LEN_W + 1)'(GRANULE_BYTES - 1);
	assign need_full = need_sum >> GRAN_SH;
	assign need_d    = CW'(need_full);

	// header granule lies one below the payload granule
	assign pg    = payload_address >> GRAN_SH;
	assign pg_x  = CW'(pg);
	assign pg_ok = (pg_x != '0) && (pg_x <= G_CW);

	assign rd_sz   = ram_rdata[GW-1:0];
	assign rd_used = ram_rdata[GW];
	assign rd_sz_x = CW'(rd_sz);
	assign fit     = !rd_used && (rd_sz_x >= need_q);
	assign big     = rd_sz_x >= need_p2_q;

	// saturate a merged size at the pool's granule count minus one
	assign alu_sat  = alu_flags.lt ? alu_sum[GW-1:0] : GMAX_GW;
	assign byte_off = {alu_sum, {GRAN_SH{1'b0}}};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_ALLOC: begin
							if (!ready_q) begin
								state_d = S_A_INIT;
							end else if (need_d != '0) begin
								state_d = S_A_RD;
							end
						end
						CMD_FREE: begin
							if (!address_is_null && pg_ok) begin
								state_d = S_F_RDH;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_A_INIT: state_d = (need_q == '0) ? S_IDLE : S_A_RD;
			S_A_RD:   state_d = S_A_CHK;
			S_A_CHK: begin
				if (fit) begin
					state_d = big ? S_A_SPN : S_A_MARK;
				end else begin
					state_d = alu_flags.lt ? S_A_RD : S_IDLE;
				end
			end
			S_A_SPN:  state_d = alu_flags.lt ? S_A_SPS : S_A_MARK;
			S_A_SPS:  state_d = S_A_MARK;
			S_A_MARK: state_d = S_IDLE;
			S_F_RDH:  state_d = S_F_CHKH;
			S_F_CHKH: state_d = alu_flags.lt ? S_F_RDN : S_F_WRH;
			S_F_RDN:  state_d = S_F_CHKN;
			S_F_CHKN: state_d = S_F_WRH;
			S_F_WRH:  state_d = (h_q == '0) ? S_IDLE : S_F_RDW;
			S_F_RDW:  state_d = S_F_CHKW;
			S_F_CHKW: begin
				if (alu_flags.eq) begin
					state_d = rd_used ? S_IDLE : S_F_MRG;
				end else begin
					state_d = alu_flags.lt ? S_F_RDW : S_IDLE;
				end
			end
			S_F_MRG:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// RAM, shared-unit and finish controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		alu_a     = '0;
		alu_b     = '0;
		alu_c     = G_CW;
		alu_cin   = 1'b1;
		alu_sub   = 1'b0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_addr  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_ALLOC: begin
							fin = ready_q && (need_d == '0);
						end
						CMD_FREE: begin
							fin    = address_is_null || !pg_ok;
							fin_ok = 1'b1;
						end
						CMD_RESET: begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_A_INIT: begin
				// rebuild a single free root block
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {1'b0, GMAX_GW};
				fin       = need_q == '0;
			end
			S_A_RD: begin
				ram_raddr = cur_q[GW-1:0];
			end
			S_A_CHK: begin
				alu_a = cur_q;
				alu_b = rd_sz_x;
				fin   = !fit && !alu_flags.lt;
			end
			S_A_SPN: begin
				alu_a = cur_q;
				alu_b = need_q;
			end
			S_A_SPS: begin
				// remainder size: sz - need - 1
				alu_a     = CW'(sz_q);
				alu_b     = need_q;
				alu_cin   = 1'b0;
				alu_sub   = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = nb_q;
				ram_wdata = {1'b0, alu_sum[GW-1:0]};
			end
			S_A_MARK: begin
				alu_a     = cur_q;
				ram_we    = 1'b1;
				ram_waddr = cur_q[GW-1:0];
				ram_wdata = {1'b1, mark_q};
				fin       = 1'b1;
				fin_ok    = 1'b1;
				fin_addr  = byte_off[ADDR_W-1:0];
			end
			S_F_RDH: begin
				ram_raddr = h_q;
			end
			S_F_CHKH: begin
				alu_a = CW'(h_q);
				alu_b = rd_sz_x;
			end
			S_F_RDN: begin
				ram_raddr = nxt_q;
			end
			S_F_CHKN: begin
				alu_a = CW'(szh_q);
				alu_b = rd_sz_x;
			end
			S_F_WRH: begin
				ram_we    = 1'b1;
				ram_waddr = h_q;
				ram_wdata = {1'b0, szh_q};
				fin       = h_q == '0;
				fin_ok    = 1'b1;
			end
			S_F_RDW: begin
				ram_raddr = cur_q[GW-1:0];
			end
			S_F_CHKW: begin
				alu_a  = cur_q;
				alu_b  = rd_sz_x;
				alu_c  = CW'(h_q);
				fin    = (alu_flags.eq && rd_used) || (!alu_flags.eq && !alu_flags.lt);
				fin_ok = 1'b1;
			end
			S_F_MRG: begin
				// fold the freed block into its free predecessor
				alu_a     = CW'(sz_q);
				alu_b     = CW'(szh_q);
				ram_we    = 1'b1;
				ram_waddr = cur_q[GW-1:0];
				ram_wdata = {1'b0, alu_sat};
				fin       = 1'b1;
				fin_ok    = 1'b1;
			end
			default: fin = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_A_INIT) begin
				ready_q <= 1'b1;
			end else if (acc && (command == CMD_RESET)) begin
				ready_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin) begin
			addr_q <= fin_addr;
			ok_q   <= fin_ok;
		end
		case (state_q)
			S_IDLE: begin
				need_q    <= need_d;
				need_p2_q <= need_d + CW'(2);
				h_q       <= GW'(pg_x - CW'(1));
				cur_q     <= '0;
			end
			S_A_CHK: begin
				sz_q   <= rd_sz;
				mark_q <= rd_sz;
				if (!fit) begin
					cur_q <= alu_sum;
				end
			end
			S_A_SPN: begin
				nb_q <= alu_sum[GW-1:0];
			end
			S_A_SPS: begin
				mark_q <= need_q[GW-1:0];
			end
			S_F_CHKH: begin
				szh_q <= rd_sz;
				nxt_q <= alu_sum[GW-1:0];
			end
			S_F_CHKN: begin
				if (!rd_used) begin
					szh_q <= alu_sat;
				end
			end
			S_F_WRH: begin
				cur_q <= '0;
			end
			S_F_CHKW: begin
				sz_q <= rd_sz;
				if (!alu_flags.eq) begin
					cur_q <= alu_sum;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign done           = done_q;
	assign result_address = addr_q;
	assign success        = ok_q;

	`FFBA_ASSERT_NEXT(a_beat_answered, clk, arst_n, acc, busy || done_q, "accepted beat neither worked nor answered")
	`FFBA_ASSERT_NOW(a_fail_no_addr, clk, arst_n, done_q && !ok_q, addr_q == '0, "failed result carries an address")
	`FFBA_ASSERT_NOW(a_write_busy, clk, arst_n, ram_we, busy, "header write while idle")
	`FFBA_ASSERT_NEXT(a_root_ready, clk, arst_n, state_q == S_A_INIT, ready_q, "pool not ready after root rebuild")

endmodule

// ===== hw/rtl/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/ffba_alu.sv =====
// Shared adder/subtractor with compare against a bound.
module ffba_alu #(
	parameter int W = 14
) (
	input  logic                  cin,
	input  logic                  sub,
	input  logic [W-1:0]          a,
	input  logic [W-1:0]          b,
	input  logic [W-1:0]          c,
	output logic [W-1:0]          sum,
	output ffba_pkg::alu_flags_t  flags
);
	import ffba_pkg::*;

	logic [W-1:0] b_eff;

	assign b_eff    = sub ? ~b : b;
	assign sum      = a + b_eff + W'(cin);
	assign flags.lt = sum < c;
	assign flags.eq = sum == c;

endmodule
